// ===== hw/rtl/ktis_pkg.sv =====
// Package for the keyed table core: table sizing, operation and status codes,
// and the controller state and command types. No dependencies.
package ktis_pkg;

  localparam int ENTRIES    = 16;
  localparam int DATA_WIDTH = 32;
  localparam int KEY_W      = 32;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int WORD_W     = KEY_W + DATA_WIDTH;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED       = 3'd0,
    ST_DUPLICATE      = 3'd1,
    ST_FULL           = 3'd2,
    ST_REMOVED        = 3'd3,
    ST_NOT_FOUND      = 3'd4,
    ST_FOUND          = 3'd5,
    ST_NOT_FOUND_FULL = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } ctl_sts_t;

endpackage

// ===== hw/rtl/ktis_in_if.sv =====
// Operation channel interface: valid/ready handshake plus one operation beat.
// Depends on ktis_pkg for field widths.
interface ktis_in_if;
  logic                             valid;
  logic                             ready;
  logic [ktis_pkg::OP_W-1:0]        operation;
  logic signed [ktis_pkg::KEY_W-1:0] lookup_key;
  logic [ktis_pkg::DATA_WIDTH-1:0]  entry_data;

  modport source (output valid, operation, lookup_key, entry_data, input ready);
  modport sink   (input valid, operation, lookup_key, entry_data, output ready);
endinterface

// ===== hw/rtl/ktis_out_if.sv =====
// Result channel interface: valid/ready handshake plus one result beat.
// Depends on ktis_pkg for field widths.
interface ktis_out_if;
  logic                          valid;
  logic                          ready;
  logic [ktis_pkg::STATUS_W-1:0] status;
  logic [ktis_pkg::IDX_W-1:0]    slot_index;
  logic [ktis_pkg::CNT_W-1:0]    occupancy;

  modport source (output valid, status, slot_index, occupancy, input ready);
  modport sink   (input valid, status, slot_index, occupancy, output ready);
endinterface

// ===== hw/rtl/keyed_table_insert_remove_search_core.sv =====
// Keyed table core: insert, remove and search over a table of key/payload
// entries by linear scan. Depends on ktis_pkg, ktis_in_if, ktis_out_if,
// ktis_ctrl and ktis_dp.
//
//   channel  | dir | handshake            | beat
//   ---------+-----+----------------------+--------------------------------------
//   in_bus   | in  | valid/ready          | operation, lookup_key, entry_data
//   out_bus  | out | valid/ready          | status, slot_index, occupancy
//
// Each operation scans the key RAM: one read per entry, each entry compared
// on the step after its read since the RAM read data is registered, then a
// trailing compare of the last entry, a step to see the scan end, and a resolve.
// One operation is in flight at a time; the next beat is taken the cycle after
// the result is registered, even while that result still waits on
// out_bus; no new operation is taken while one is being scanned or resolved.
// A stalled result holds the core in its resolve step only if a second
// result is ready to overwrite it. Reset is synchronous and clears all valid
// marks and the occupancy count; no clearing pass is needed.
module keyed_table_insert_remove_search_core (
  input  logic       clk,
  input  logic       rst_n,
  ktis_in_if.sink    in_bus,
  ktis_out_if.source out_bus
);

  ktis_pkg::ctl_cmd_t cmd;
  ktis_pkg::ctl_sts_t sts;

  // sequence each operation: accept, scan, resolve
  ktis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // hold the table and the result register
  ktis_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .operation  (in_bus.operation),
    .lookup_key (in_bus.lookup_key),
    .entry_data (in_bus.entry_data),
    .out_ready  (out_bus.ready),
    .out_valid  (out_bus.valid),
    .status     (out_bus.status),
    .slot_index (out_bus.slot_index),
    .occupancy  (out_bus.occupancy)
  );

endmodule

// ===== hw/rtl/ktis_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ktis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/ktis_ctrl.sv =====
// Controller FSM for the keyed table: sequences load, scan and finish.
// Depends on ktis_pkg.
module ktis_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ktis_pkg::ctl_sts_t sts,
  output ktis_pkg::ctl_cmd_t cmd
);

  ktis_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ktis_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ktis_pkg::S_IDLE: if (in_valid)      state_nxt = ktis_pkg::S_SCAN;
      ktis_pkg::S_SCAN: if (sts.scan_done) state_nxt = ktis_pkg::S_DONE;
      ktis_pkg::S_DONE: if (sts.out_free)  state_nxt = ktis_pkg::S_IDLE;
      default:                             state_nxt = ktis_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    case (state_r)
      ktis_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ktis_pkg::S_SCAN: cmd.step   = !sts.scan_done;
      ktis_pkg::S_DONE: cmd.finish = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/ktis_dp.sv =====
// Datapath for the keyed table: valid marks, occupancy, key/payload RAM,
// scan counter, match and free-slot tracking, result register.
// Depends on ktis_pkg and ktis_ram.
module ktis_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ktis_pkg::ctl_cmd_t                  cmd,
  output ktis_pkg::ctl_sts_t                  sts,
  input  logic [ktis_pkg::OP_W-1:0]           operation,
  input  logic signed [ktis_pkg::KEY_W-1:0]   lookup_key,
  input  logic [ktis_pkg::DATA_WIDTH-1:0]     entry_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [ktis_pkg::STATUS_W-1:0]       status,
  output logic [ktis_pkg::IDX_W-1:0]          slot_index,
  output logic [ktis_pkg::CNT_W-1:0]          occupancy
);

  localparam logic [ktis_pkg::CNT_W-1:0] FULL_CNT = ktis_pkg::CNT_W'(ktis_pkg::ENTRIES);

  // operation latched at accept
  logic [ktis_pkg::OP_W-1:0]       op_r;
  logic [ktis_pkg::KEY_W-1:0]      key_r;
  logic [ktis_pkg::DATA_WIDTH-1:0] data_r;

  // scan state
  logic [ktis_pkg::CNT_W-1:0] cnt_r;
  logic                       rd_pend_r;
  logic [ktis_pkg::IDX_W-1:0] rd_idx_r;
  logic                       hit_r, free_r;
  logic [ktis_pkg::IDX_W-1:0] hit_idx_r, free_idx_r;

  // table state
  logic [ktis_pkg::ENTRIES-1:0] valid_r, valid_nxt;
  logic [ktis_pkg::CNT_W-1:0]   count_r, count_nxt;

  // result register
  logic                          out_valid_r;
  logic [ktis_pkg::STATUS_W-1:0] out_status_r;
  logic [ktis_pkg::IDX_W-1:0]    out_slot_r;
  logic [ktis_pkg::CNT_W-1:0]    out_occ_r;

  ktis_pkg::status_t           status_nxt;
  logic [ktis_pkg::IDX_W-1:0]  slot_nxt;
  logic                        wr_en;
  logic                        rd_en;
  logic                        scan_end;
  logic                        key_match;
  logic [ktis_pkg::WORD_W-1:0] rd_word;

  assign scan_end  = (cnt_r == FULL_CNT);
  assign rd_en     = cmd.step && !scan_end;
  assign key_match = (rd_word[ktis_pkg::WORD_W-1 -: ktis_pkg::KEY_W] == key_r);

  assign sts.scan_done = scan_end && !rd_pend_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  ktis_ram #(
    .WIDTH (ktis_pkg::WORD_W),
    .DEPTH (ktis_pkg::ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (free_idx_r),
    .wr_data ({key_r, data_r}),
    .rd_en   (rd_en),
    .rd_addr (cnt_r[ktis_pkg::IDX_W-1:0]),
    .rd_data (rd_word)
  );

  // Resolve the operation once the scan is complete.
  always_comb begin
    status_nxt = ktis_pkg::ST_NOT_FOUND;
    slot_nxt   = '0;
    valid_nxt  = valid_r;
    count_nxt  = count_r;
    wr_en      = 1'b0;
    case (op_r)
      ktis_pkg::OP_INSERT: begin
        if (count_r == FULL_CNT) begin
          status_nxt = ktis_pkg::ST_FULL;
        end else if (hit_r) begin
          status_nxt = ktis_pkg::ST_DUPLICATE;
          slot_nxt   = hit_idx_r;
        end else if (!free_r) begin
          status_nxt = ktis_pkg::ST_FULL;
        end else begin
          status_nxt            = ktis_pkg::ST_INSERTED;
          slot_nxt              = free_idx_r;
          valid_nxt[free_idx_r] = 1'b1;
          count_nxt             = count_r + 1'b1;
          wr_en                 = cmd.finish;
        end
      end
      ktis_pkg::OP_REMOVE: begin
        if (count_r != '0 && hit_r) begin
          status_nxt           = ktis_pkg::ST_REMOVED;
          slot_nxt             = hit_idx_r;
          valid_nxt[hit_idx_r] = 1'b0;
          count_nxt            = count_r - 1'b1;
        end
      end
      default: begin
        if (hit_r) begin
          status_nxt = ktis_pkg::ST_FOUND;
          slot_nxt   = hit_idx_r;
        end else if (free_r) begin
          slot_nxt = free_idx_r;
        end else begin
          status_nxt = ktis_pkg::ST_NOT_FOUND_FULL;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
    end else begin
      if (cmd.load) begin
        cnt_r     <= '0;
        rd_pend_r <= 1'b0;
        hit_r     <= 1'b0;
        free_r    <= 1'b0;
      end else if (cmd.step) begin
        // advance the read address; compare the entry read last cycle
        if (!scan_end) begin
          cnt_r <= cnt_r + 1'b1;
        end
        rd_pend_r <= !scan_end;
        if (rd_pend_r) begin
          if (valid_r[rd_idx_r]) begin
            if (key_match && !hit_r) begin
              hit_r <= 1'b1;
            end
          end else begin
            free_r <= 1'b1;
          end
        end
      end
      if (cmd.finish) begin
        valid_r     <= valid_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= operation;
      key_r  <= $unsigned(lookup_key);
      data_r <= entry_data;
    end
    if (rd_en) begin
      rd_idx_r <= cnt_r[ktis_pkg::IDX_W-1:0];
    end
    if (cmd.step && rd_pend_r) begin
      if (valid_r[rd_idx_r]) begin
        if (key_match && !hit_r) begin
          hit_idx_r <= rd_idx_r;
        end
      end else begin
        free_idx_r <= rd_idx_r;
      end
    end
    if (cmd.finish) begin
      out_status_r <= status_nxt;
      out_slot_r   <= slot_nxt;
      out_occ_r    <= count_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign status     = out_status_r;
  assign slot_index = out_slot_r;
  assign occupancy  = out_occ_r;

  a_count_matches_marks: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == ktis_pkg::CNT_W'($countones(valid_r)))
    else $error("occupancy disagrees with valid marks");

  a_finish_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.finish))
    else $error("result raised without finish");

  a_insert_sets_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && status_nxt == ktis_pkg::ST_INSERTED) |=> valid_r[$past(free_idx_r)])
    else $error("inserted entry not marked valid");

  a_scan_quiet_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (scan_end && !rd_pend_r))
    else $error("finish before scan complete");

endmodule

// ===== test/ktis_table_checker.sv =====
`timescale 1ns / 1ps
// Checker for the keyed table core: watches both channels, predicts each result beat
// from its own copy of the table, and compares. Depends on ktis_pkg, ktis_in_if, ktis_out_if.
module ktis_table_checker
  import ktis_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ktis_in_if         in_mon,
  ktis_out_if        out_mon,
  output int         fail_count,
  output int         pending,
  output int         checked,
  output int         full_hits
);

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] occ;
  } table_outcome_t;

  // Shadow table; keys of entries never marked valid are never compared.
  logic [ENTRIES-1:0] tbl_valid;
  logic [KEY_W-1:0]   tbl_key [ENTRIES];
  logic [CNT_W-1:0]   tbl_count;

  table_outcome_t outcome_q[$];
  int fails;
  int n_checked;
  int n_full;

  // Scan from index 0 up until a valid key match: keep that match and the last free entry seen.
  function automatic table_outcome_t table_outcome(input logic [OP_W-1:0] op,
                                                   input logic [KEY_W-1:0] key);
    table_outcome_t res;
    logic hit;
    logic has_free;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] free_idx;
    hit = 1'b0;
    has_free = 1'b0;
    hit_idx = '0;
    free_idx = '0;
    res.status = ST_NOT_FOUND;
    res.slot = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!hit) begin
        if (tbl_valid[i]) begin
          if (tbl_key[i] == key) begin
            hit = 1'b1;
            hit_idx = IDX_W'(i);
          end
        end else begin
          has_free = 1'b1;
          free_idx = IDX_W'(i);
        end
      end
    end
    case (op)
      OP_INSERT: begin
        if (tbl_count >= ENTRIES || (!hit && !has_free)) begin
          res.status = ST_FULL;
        end else if (hit) begin
          res.status = ST_DUPLICATE;
          res.slot = hit_idx;
        end else begin
          tbl_valid[free_idx] = 1'b1;
          tbl_key[free_idx] = key;
          tbl_count++;
          res.status = ST_INSERTED;
          res.slot = free_idx;
        end
      end
      OP_REMOVE: begin
        if (tbl_count != 0 && hit) begin
          tbl_valid[hit_idx] = 1'b0;
          tbl_count--;
          res.status = ST_REMOVED;
          res.slot = hit_idx;
        end
      end
      default: begin
        if (hit) begin
          res.status = ST_FOUND;
          res.slot = hit_idx;
        end else if (has_free) begin
          res.slot = free_idx;
        end else begin
          res.status = ST_NOT_FOUND_FULL;
        end
      end
    endcase
    res.occ = tbl_count;
    return res;
  endfunction

  initial begin
    fails = 0;
    n_checked = 0;
    n_full = 0;
    fail_count = 0;
    pending = 0;
    checked = 0;
    full_hits = 0;
    tbl_valid = '0;
    tbl_count = '0;
  end

  always @(posedge clk) begin
    table_outcome_t want;
    if (!rst_n) begin
      tbl_valid = '0;
      tbl_count = '0;
      outcome_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        want = table_outcome(in_mon.operation, in_mon.lookup_key);
        if (want.occ == ENTRIES) n_full++;
        outcome_q.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (outcome_q.size() == 0) begin
          $error("result beat with nothing expected: status %0d slot_index %0d occupancy %0d",
                 out_mon.status, out_mon.slot_index, out_mon.occupancy);
          fails++;
        end else begin
          want = outcome_q.pop_front();
          n_checked++;
          if (out_mon.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_mon.status);
            fails++;
          end
          if (out_mon.slot_index !== want.slot) begin
            $error("slot_index: expected %0d, got %0d", want.slot, out_mon.slot_index);
            fails++;
          end
          if (out_mon.occupancy !== want.occ) begin
            $error("occupancy: expected %0d, got %0d", want.occ, out_mon.occupancy);
            fails++;
          end
        end
      end
    end
    fail_count <= fails;
    pending    <= outcome_q.size();
    checked    <= n_checked;
    full_hits  <= n_full;
  end

endmodule

// ===== test/tb_keyed_table_insert_remove_search_core.sv =====
`timescale 1ns / 1ps
// Top of the keyed table testbench: clock, reset, operation stimulus and result
// back-pressure, verdict. Depends on ktis_pkg, both channel interfaces and ktis_table_checker.
module tb_keyed_table_insert_remove_search_core;
  import ktis_pkg::*;

  // Operation code 3 is decoded as a search by the core.
  localparam logic [OP_W-1:0] OP_SEARCH_ALIAS = 2'd3;
  localparam int RANDOM_ITEMS = 2000;
  localparam int KEY_POOL     = 24;
  localparam int MAX_GAP      = 12;
  // Drain tail after the last result: room for about two full operations.
  localparam int DRAIN_CYCLES = 2 * (ENTRIES + 4);

  // Operation mix of one random phase: fill the table, drain it, or hover.
  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } op_mix_t;

  logic clk;
  logic rst_n;

  ktis_in_if  in_bus();
  ktis_out_if out_bus();

  int mismatches;
  int pending;
  int checked;
  int full_hits;

  // Sender and receiver side bookkeeping.
  logic tx_calm;
  logic rx_calm;
  int   n_insert;
  int   n_remove;
  int   n_search;
  logic [KEY_W-1:0] key_pool [KEY_POOL];

  keyed_table_insert_remove_search_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  ktis_table_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .fail_count (mismatches),
    .pending    (pending),
    .checked    (checked),
    .full_hits  (full_hits)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Offer one operation beat and hold it until the core takes it. Call right
  // after a rising edge; returns right after the accepting edge. A zero gap
  // keeps valid high straight into the next beat, so valid never gets two
  // updates in one step.
  task automatic send_op(input logic [OP_W-1:0]       op,
                         input logic [KEY_W-1:0]      key,
                         input logic [DATA_WIDTH-1:0] data);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.operation  <= op;
    in_bus.lookup_key <= key;
    in_bus.entry_data <= data;
    do @(posedge clk); while (!in_bus.ready);
    case (op)
      OP_INSERT: n_insert++;
      OP_REMOVE: n_remove++;
      default:   n_search++;
    endcase
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [OP_W-1:0] pick_op(input op_mix_t mix);
    int r;
    int ins_cut;
    int rem_cut;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        ins_cut = 60;
        rem_cut = 75;
      end
      MIX_DRAIN: begin
        ins_cut = 15;
        rem_cut = 70;
      end
      default: begin
        ins_cut = 35;
        rem_cut = 70;
      end
    endcase
    if (r < ins_cut) return OP_INSERT;
    if (r < rem_cut) return OP_REMOVE;
    if (r < 95) return OP_SEARCH;
    return OP_SEARCH_ALIAS;
  endfunction

  // Mostly reuse a small key set so that hits, duplicates and removals are
  // common; the pool is larger than the table so misses on a full table occur.
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, KEY_POOL - 1)];
    return $urandom;
  endfunction

  // Result side: for each result beat, hold ready low for a random number of
  // cycles while valid is up; now and then run a stretch with no stalls.
  initial begin : result_sink
    int stall;
    int beats;
    stall = 0;
    beats = 0;
    rx_calm = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_bus.valid && out_bus.ready) begin
        beats++;
        if (beats % 60 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      end else if (stall > 0 && out_bus.valid) begin
        stall--;
      end
      out_bus.ready <= (stall == 0);
    end
  end

  initial begin : stimulus
    op_mix_t mix;
    int sent;
    int phase_len;
    in_bus.valid      <= 1'b0;
    in_bus.operation  <= OP_INSERT;
    in_bus.lookup_key <= '0;
    in_bus.entry_data <= '0;
    rst_n    <= 1'b0;
    tx_calm  = 1'b0;
    n_insert = 0;
    n_remove = 0;
    n_search = 0;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < KEY_POOL; i++) key_pool[i] = $urandom;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Empty table: search reports the top free slot, remove misses.
    send_op(OP_SEARCH, 32'h0000_0000, 32'h0);
    send_op(OP_REMOVE, 32'h0000_0000, 32'h0);
    // Key extremes go in from the top slot down; payload extremes ride along.
    send_op(OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 32'h7FFF_FFFF, 32'h0000_0000);
    send_op(OP_INSERT, 32'h0000_0000, 32'hA5A5_A5A5);
    send_op(OP_INSERT, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
    // Duplicate insert reports the slot of the existing key.
    send_op(OP_INSERT, 32'h8000_0000, 32'h1234_5678);
    send_op(OP_SEARCH, 32'h7FFF_FFFF, 32'h0);
    send_op(OP_SEARCH_ALIAS, 32'hFFFF_FFFF, 32'h0);
    // Remove of an absent key, then a real removal and a search for the hole.
    send_op(OP_REMOVE, 32'h0000_1234, 32'h0);
    send_op(OP_REMOVE, 32'h0000_0000, 32'h0);
    send_op(OP_SEARCH, 32'h0000_0000, 32'h0);
    // Fill the table: three entries remain, thirteen more make it full.
    for (int i = 0; i < ENTRIES - 3; i++) send_op(OP_INSERT, 32'h0000_0100 + i, $urandom);
    // Full table: new key, present key, search miss, search hit through code 3.
    send_op(OP_INSERT, 32'h0000_0055, $urandom);
    send_op(OP_INSERT, 32'h7FFF_FFFF, $urandom);
    send_op(OP_SEARCH, 32'h0000_0055, 32'h0);
    send_op(OP_SEARCH_ALIAS, 32'h8000_0000, 32'h0);
    wait_idle();

    // Random part in phases; hold off at each phase boundary until idle.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      mix       = op_mix_t'($urandom_range(0, 2));
      tx_calm   = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(40, 120);
      for (int j = 0; j < phase_len && sent < RANDOM_ITEMS; j++) begin
        send_op(pick_op(mix), pick_key(), $urandom);
        sent++;
      end
    end

    // Drain: wait for the last result, then give stray beats time to show.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Drove %0d operations: %0d inserts, %0d removes, %0d searches",
             n_insert + n_remove + n_search, n_insert, n_remove, n_search);
    $display("Compared %0d result beats, %0d of them with all %0d entries in use",
             checked, full_hits, ENTRIES);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake; far above the slowest legal run.
  initial begin : run_limit
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
